@@ design/queue_from_two_stacks_macros.svh @@
// Assertion macros for the two-stack queue checker.
// Used by qfts_checker; needs signals named clk and rst_n in scope.
`ifndef QUEUE_FROM_TWO_STACKS_MACROS_SVH
`define QUEUE_FROM_TWO_STACKS_MACROS_SVH

// Clocked check, disabled while reset is asserted.
`define QFTS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also runs during reset.
`define QFTS_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ design/qfts_pkg.sv @@
// Shared types and constants for the two-stack queue.
// No dependencies; imported by every module of the block.
package qfts_pkg;

  localparam int DATA_W        = 32;
  localparam int DEF_MAX_DEPTH = 16;
  localparam int CAP_W         = 5;
  localparam int STATUS_W      = 2;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  // operation codes
  localparam logic KIND_ENQ = 1'b0;
  localparam logic KIND_DEQ = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] STAT_OK  = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_OVF = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_UNF = 2'd2;

  localparam logic signed [DATA_W-1:0] UNDERFLOW_VALUE = -32'sd1;

  // per-cycle command to a stack of cells
  typedef struct packed {
    logic push;
    logic pop;
  } stack_ctrl_t;

endpackage

@@ design/qfts_cell.sv @@
// One storage cell of a shift-register stack.
// Depends on qfts_pkg for stack_ctrl_t and DATA_W.
module qfts_cell import qfts_pkg::*; (
  input  logic              clk,
  input  stack_ctrl_t       ctrl,
  input  logic [DATA_W-1:0] above_data,
  input  logic [DATA_W-1:0] below_data,
  output logic [DATA_W-1:0] data_out
);

  logic [DATA_W-1:0] data_r;
  logic [DATA_W-1:0] data_nxt;

  // push shifts down from the neighbor above, pop shifts up from below
  always_comb begin
    data_nxt = data_r;
    if (ctrl.push) begin
      data_nxt = above_data;
    end else if (ctrl.pop) begin
      data_nxt = below_data;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_out = data_r;

endmodule

@@ design/qfts_stack.sv @@
// Bounded stack built as a row of qfts_cell; cell 0 is the top.
// Depends on qfts_pkg and qfts_cell.
module qfts_stack import qfts_pkg::*; #(
  parameter int DEPTH = DEF_MAX_DEPTH,
  parameter int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  stack_ctrl_t       ctrl,
  input  logic [DATA_W-1:0] push_data,
  output logic [DATA_W-1:0] top_data,
  output logic [CNT_W-1:0]  count
);

  logic [DATA_W-1:0] cell_q [DEPTH];
  logic [CNT_W-1:0]  count_r;
  logic [CNT_W-1:0]  count_nxt;

  // row of cells, each fed by its two neighbors
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_W-1:0] above;
    logic [DATA_W-1:0] below;
    if (i == 0) begin : g_top
      assign above = push_data;
    end else begin : g_mid
      assign above = cell_q[i-1];
    end
    if (i == DEPTH - 1) begin : g_bot
      assign below = '0;
    end else begin : g_up
      assign below = cell_q[i+1];
    end
    qfts_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .above_data (above),
      .below_data (below),
      .data_out   (cell_q[i])
    );
  end

  // fill level
  always_comb begin
    count_nxt = count_r;
    if (ctrl.push) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (ctrl.pop) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  assign top_data = cell_q[0];
  assign count    = count_r;

endmodule

@@ design/queue_from_two_stacks.sv @@
// Top level of the FIFO queue made from two bounded cell-chain stacks.
// Depends on qfts_pkg and qfts_stack.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+------------------------------
//  in      | to block  | in_valid / in_stall | in_kind, in_write_value
//  out     | from block| out_valid/out_stall | out_read_value, out_status
//  cfg     | to block  | cfg_wr_en           | cfg_wr_data (capacity)
//
// An enqueue or a dequeue from a non-empty output stack is served from idle.
// A dequeue that finds only the output stack empty first refills it, one
// entry per cycle through the cell chains, then pops the new top.
// Synchronous reset empties both stacks and sets capacity to 16.
// A result waits in the output register; the next item is taken while it
// is being transferred, and in_stall stays high while it is held back.
module queue_from_two_stacks import qfts_pkg::*; #(
  parameter int MAX_DEPTH = DEF_MAX_DEPTH
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_wr_en,
  input  logic [CAP_W-1:0]           cfg_wr_data,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       in_kind,
  input  logic signed [DATA_W-1:0]   in_write_value,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [DATA_W-1:0]   out_read_value,
  output logic [STATUS_W-1:0]        out_status
);

  localparam int CNT_W = $clog2(MAX_DEPTH + 1);
  localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  localparam logic ST_IDLE   = 1'b0;
  localparam logic ST_REFILL = 1'b1;

  logic                     state_r, state_nxt;
  logic [CAP_W-1:0]         cap_r;
  logic                     out_valid_r, out_valid_nxt;
  logic signed [DATA_W-1:0] read_r, read_nxt;
  logic [STATUS_W-1:0]      status_r, status_nxt;
  logic                     load;

  stack_ctrl_t              in_ctrl, out_ctrl;
  logic [DATA_W-1:0]        in_top, out_top;
  logic [CNT_W-1:0]         in_cnt, out_cnt;
  logic [CAP_W-1:0]         cap_lo;
  logic                     in_full;
  logic                     out_free;
  logic                     accept;

  // handshake
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != ST_IDLE) || !out_free;
  assign accept   = in_valid && !in_stall;

  // capacity clamp: zero acts as one, above MAX_DEPTH caught by count limit
  assign cap_lo  = (cap_r == '0) ? CAP_W'(1) : cap_r;
  assign in_full = (in_cnt == CNT_W'(MAX_DEPTH)) || (CMP_W'(in_cnt) >= CMP_W'(cap_lo));

  // sequencer
  always_comb begin
    state_nxt  = state_r;
    in_ctrl    = '0;
    out_ctrl   = '0;
    load       = 1'b0;
    read_nxt   = read_r;
    status_nxt = status_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_kind == KIND_ENQ) begin
            load     = 1'b1;
            read_nxt = '0;
            if (in_full) begin
              status_nxt = STAT_OVF;
            end else begin
              in_ctrl.push = 1'b1;
              status_nxt   = STAT_OK;
            end
          end else if (out_cnt != '0) begin
            out_ctrl.pop = 1'b1;
            load         = 1'b1;
            read_nxt     = $signed(out_top);
            status_nxt   = STAT_OK;
          end else if (in_cnt != '0) begin
            state_nxt = ST_REFILL;
          end else begin
            load       = 1'b1;
            read_nxt   = UNDERFLOW_VALUE;
            status_nxt = STAT_UNF;
          end
        end
      end
      ST_REFILL: begin
        if (in_cnt != '0) begin
          in_ctrl.pop   = 1'b1;
          out_ctrl.push = 1'b1;
        end else begin
          out_ctrl.pop = 1'b1;
          load         = 1'b1;
          read_nxt     = $signed(out_top);
          status_nxt   = STAT_OK;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid_nxt = load || (out_valid_r && out_stall);

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      cap_r       <= CAP_RESET;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        cap_r <= cfg_wr_data;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (load) begin
      read_r   <= read_nxt;
      status_r <= status_nxt;
    end
  end

  qfts_stack #(.DEPTH(MAX_DEPTH), .CNT_W(CNT_W)) u_in_stack (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (in_ctrl),
    .push_data ($unsigned(in_write_value)),
    .top_data  (in_top),
    .count     (in_cnt)
  );

  qfts_stack #(.DEPTH(MAX_DEPTH), .CNT_W(CNT_W)) u_out_stack (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (out_ctrl),
    .push_data (in_top),
    .top_data  (out_top),
    .count     (out_cnt)
  );

  assign out_valid      = out_valid_r;
  assign out_read_value = read_r;
  assign out_status     = status_r;

endmodule

@@ design/qfts_checker.sv @@
// Port-level checks for queue_from_two_stacks, with the bind that attaches them.
// Depends on qfts_pkg and queue_from_two_stacks_macros.svh.
`include "queue_from_two_stacks_macros.svh"

module qfts_checker import qfts_pkg::*; (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_valid,
  input logic                     in_stall,
  input logic                     in_kind,
  input logic                     out_valid,
  input logic                     out_stall,
  input logic signed [DATA_W-1:0] out_read_value,
  input logic [STATUS_W-1:0]      out_status
);

  // a held result keeps its payload
  `QFTS_ASSERT(a_out_hold,
    (out_valid && out_stall) |=>
      (out_valid && $stable(out_read_value) && $stable(out_status)),
    "result changed while stalled")

  // underflow always reads as minus one
  `QFTS_ASSERT(a_unf_value,
    (out_valid && out_status == STAT_UNF) |-> (out_read_value == UNDERFLOW_VALUE),
    "underflow value wrong")

  // an enqueue transfer gives its result in the next cycle, reading zero
  `QFTS_ASSERT(a_enq_result,
    (in_valid && !in_stall && in_kind == KIND_ENQ) |=>
      (out_valid && out_read_value == '0 && out_status != STAT_UNF),
    "enqueue result missing")

  // reset leaves no result pending
  `QFTS_ASSERT_RST(a_rst_empty, !rst_n |=> !out_valid, "result valid after reset")

endmodule

bind queue_from_two_stacks qfts_checker u_qfts_checker (.*);
